[rtl/tcb_pkg.sv]
package tcb_pkg;

  typedef enum logic [3:0] {
    ELEM_U8  = 4'd0,
    ELEM_S8  = 4'd1,
    ELEM_U16 = 4'd2,
    ELEM_S16 = 4'd3,
    ELEM_U32 = 4'd4,
    ELEM_S32 = 4'd5,
    ELEM_U64 = 4'd6,
    ELEM_S64 = 4'd7,
    ELEM_F32 = 4'd8,
    ELEM_F64 = 4'd9
  } elem_type_e;

  typedef enum logic [1:0] {
    OP_EQ = 2'd0,
    OP_NE = 2'd1,
    OP_GT = 2'd2,
    OP_GE = 2'd3
  } cmp_op_e;

  typedef enum logic [1:0] {
    MODE_BOTH     = 2'd0,
    MODE_R_SCALAR = 2'd1,
    MODE_L_SCALAR = 2'd2
  } operand_mode_e;

  localparam logic [2:0] REG_ELEM_TYPE    = 3'd0;
  localparam logic [2:0] REG_CMP_OP       = 3'd1;
  localparam logic [2:0] REG_OPERAND_MODE = 3'd2;
  localparam logic [2:0] REG_SCALAR_VALUE = 3'd3;
  localparam logic [2:0] REG_START_BIT    = 3'd4;

  // Compare settings handed to the compare unit
  typedef struct packed {
    logic [3:0] elem_type;
    logic [1:0] cmp_op;
  } cmp_cfg_t;

endpackage

[rtl/tcb_compare.sv]
module tcb_compare (
  input  tcb_pkg::cmp_cfg_t cfg_i,
  input  logic [63:0]       a_i,
  input  logic [63:0]       b_i,
  output logic              res_o
);

  logic [63:0] ka, kb;
  logic        eq, gt;
  logic        f_dbl, a_nan, b_nan, both_zero, a_neg, b_neg;
  logic [62:0] a_mag, b_mag;

  // Order-preserving keys for integer types
  always_comb begin
    ka = a_i;
    kb = b_i;
    case (cfg_i.elem_type)
      tcb_pkg::ELEM_U8:  begin ka = {56'd0, a_i[7:0]}; kb = {56'd0, b_i[7:0]}; end
      tcb_pkg::ELEM_S8:  begin
        ka = {56'd0, ~a_i[7], a_i[6:0]}; kb = {56'd0, ~b_i[7], b_i[6:0]};
      end
      tcb_pkg::ELEM_U16: begin ka = {48'd0, a_i[15:0]}; kb = {48'd0, b_i[15:0]}; end
      tcb_pkg::ELEM_S16: begin
        ka = {48'd0, ~a_i[15], a_i[14:0]}; kb = {48'd0, ~b_i[15], b_i[14:0]};
      end
      tcb_pkg::ELEM_U32: begin ka = {32'd0, a_i[31:0]}; kb = {32'd0, b_i[31:0]}; end
      tcb_pkg::ELEM_S32: begin
        ka = {32'd0, ~a_i[31], a_i[30:0]}; kb = {32'd0, ~b_i[31], b_i[30:0]};
      end
      tcb_pkg::ELEM_S64: begin
        ka = {~a_i[63], a_i[62:0]}; kb = {~b_i[63], b_i[62:0]};
      end
      default: ;
    endcase
  end

  // Float fields: sign and magnitude, single moved into the same layout
  always_comb begin
    f_dbl = (cfg_i.elem_type == tcb_pkg::ELEM_F64);
    if (f_dbl) begin
      a_neg = a_i[63]; b_neg = b_i[63];
      a_mag = a_i[62:0]; b_mag = b_i[62:0];
      a_nan = (a_i[62:52] == 11'h7ff) && (a_i[51:0] != 52'd0);
      b_nan = (b_i[62:52] == 11'h7ff) && (b_i[51:0] != 52'd0);
    end else begin
      a_neg = a_i[31]; b_neg = b_i[31];
      a_mag = {32'd0, a_i[30:0]}; b_mag = {32'd0, b_i[30:0]};
      a_nan = (a_i[30:23] == 8'hff) && (a_i[22:0] != 23'd0);
      b_nan = (b_i[30:23] == 8'hff) && (b_i[22:0] != 23'd0);
    end
    both_zero = (a_mag == 63'd0) && (b_mag == 63'd0);
  end

  // Equal and greater for the selected type
  always_comb begin
    if (cfg_i.elem_type == tcb_pkg::ELEM_F32 || cfg_i.elem_type == tcb_pkg::ELEM_F64) begin
      if (a_nan || b_nan) begin
        eq = 1'b0; gt = 1'b0;
      end else if (both_zero) begin
        eq = 1'b1; gt = 1'b0;
      end else begin
        eq = (a_neg == b_neg) && (a_mag == b_mag);
        if (a_neg != b_neg) gt = b_neg;
        else if (a_neg)     gt = a_mag < b_mag;
        else                gt = a_mag > b_mag;
      end
    end else begin
      eq = (ka == kb);
      gt = (ka > kb);
    end
  end

  // Apply the test
  always_comb begin
    case (cfg_i.cmp_op)
      tcb_pkg::OP_EQ: res_o = eq;
      tcb_pkg::OP_NE: res_o = ~eq;
      tcb_pkg::OP_GT: res_o = gt;
      default:        res_o = gt | eq;
    endcase
  end

endmodule

[rtl/typed_compare_to_bitmap_top.sv]
// Typed compare-to-bitmap packer. Each input transaction carries two raw
// 64-bit elements compared as the configured type (u/s 8..64, f32, f64 with
// IEEE NaN and signed-zero rules); one result bit per element is packed LSB
// first into bytes, starting at start_bit for an array's first element. A
// byte leaves when bit 7 is filled or at the element marked tlast, with a mask
// of valid bits. One element is taken every cycle unless a byte must leave
// while the output register still holds an untaken byte: the compare and
// bit insert sit between the input register and the packing register, and
// the output register is refilled while its byte is being taken.
module typed_compare_to_bitmap_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // left_value[63:0], right_value[127:64]
  input  logic         s_axis_tlast,  // last_item
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [15:0]  m_axis_tdata,  // bitmap_byte[7:0], bit_mask[15:8]
  output logic         m_axis_tlast   // last_byte
);

  logic [3:0]  elem_type_q;
  logic [1:0]  cmp_op_q, operand_mode_q;
  logic [63:0] scalar_q;
  logic [2:0]  start_bit_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_type_q <= '0; cmp_op_q <= '0; operand_mode_q <= '0;
      scalar_q <= '0; start_bit_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tcb_pkg::REG_ELEM_TYPE:    elem_type_q    <= cfg_data_i[3:0];
        tcb_pkg::REG_CMP_OP:       cmp_op_q       <= cfg_data_i[1:0];
        tcb_pkg::REG_OPERAND_MODE: operand_mode_q <= cfg_data_i[1:0];
        tcb_pkg::REG_SCALAR_VALUE: scalar_q       <= cfg_data_i;
        tcb_pkg::REG_START_BIT:    start_bit_q    <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Stage 1: input register
  logic        in_vld_q, in_last_q;
  logic [63:0] in_a_q, in_b_q;
  logic        adv;
  logic        out_vld_q, out_last_q;
  logic [7:0]  out_byte_q, out_mask_q;
  logic        emit;

  // Stage 2 can always move unless a byte must leave into a full output reg
  assign adv = ~(in_vld_q & emit & out_vld_q & ~m_axis_tready);
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_vld_q <= 1'b0;
    else if (adv) in_vld_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (adv && s_axis_tvalid) begin
      in_a_q    <= s_axis_tdata[63:0];
      in_b_q    <= s_axis_tdata[127:64];
      in_last_q <= s_axis_tlast;
    end
  end

  // Operand select and compare
  logic [63:0]       opa, opb;
  logic              res;
  tcb_pkg::cmp_cfg_t ccfg;

  always_comb begin
    opa = in_a_q;
    opb = in_b_q;
    case (operand_mode_q)
      tcb_pkg::MODE_R_SCALAR: opb = scalar_q;
      tcb_pkg::MODE_L_SCALAR: opa = scalar_q;
      default: ;
    endcase
    ccfg.elem_type = elem_type_q;
    ccfg.cmp_op    = cmp_op_q;
  end

  tcb_compare u_cmp (.cfg_i(ccfg), .a_i(opa), .b_i(opb), .res_o(res));

  // Bit insert into the partial byte
  logic [7:0] part_q, vbits_q, part_cur, vbits_cur, onehot;
  logic [2:0] pos_q, pos_cur;
  logic       mid_q;

  always_comb begin
    pos_cur   = mid_q ? pos_q : start_bit_q;
    part_cur  = mid_q ? part_q : 8'd0;
    vbits_cur = mid_q ? vbits_q : 8'd0;
    onehot    = 8'd1 << pos_cur;
    part_cur  = res ? (part_cur | onehot) : part_cur;
    vbits_cur = vbits_cur | onehot;
    emit      = (pos_cur == 3'd7) | in_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0; vbits_q <= '0; pos_q <= '0; mid_q <= 1'b0;
    end else if (in_vld_q && adv) begin
      if (emit) begin
        part_q <= '0; vbits_q <= '0; pos_q <= '0; mid_q <= ~in_last_q;
      end else begin
        part_q <= part_cur; vbits_q <= vbits_cur;
        pos_q <= pos_cur + 3'd1; mid_q <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (in_vld_q && adv && emit) out_vld_q <= 1'b1;
    else if (m_axis_tready) out_vld_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q && adv && emit) begin
      out_byte_q <= part_cur;
      out_mask_q <= vbits_cur;
      out_last_q <= in_last_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_mask_q, out_byte_q};
  assign m_axis_tlast  = out_last_q;

endmodule

[tb/typed_compare_to_bitmap_top_test.sv]
`timescale 1ns / 1ps

module typed_compare_to_bitmap_top_test;

  typedef struct {
    logic [63:0] left_val;
    logic [63:0] right_val;
    logic        last_elem;
  } elem_pair_t;

  typedef struct {
    logic [7:0] bits;
    logic [7:0] mask;
    logic       last_byte;
  } bitmap_byte_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [2:0]   cfg_idx_i = '0;
  logic [63:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;  // left_value[63:0], right_value[127:64]
  logic         s_axis_tlast = 1'b0;  // last_item
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [15:0]  m_axis_tdata;  // bitmap_byte[7:0], bit_mask[15:8]
  logic         m_axis_tlast;  // last_byte

  typed_compare_to_bitmap_top u_top (.*);

  always #2 clk_i = ~clk_i;

  // Shadow configuration and packing state
  logic [3:0]  cur_type;
  logic [1:0]  cur_op;
  logic [1:0]  cur_mode;
  logic [63:0] cur_scalar;
  logic [2:0]  cur_start;
  logic [7:0]  acc_bits, acc_mask;
  logic [2:0]  acc_pos;
  logic        in_array;

  elem_pair_t   pending_pairs[$];
  bitmap_byte_t expected_bytes[$];
  int           error_count = 0;

  function automatic logic compare_float(logic [63:0] a, logic [63:0] b, logic dbl,
                                         logic [1:0] op);
    logic        nan_a, nan_b, zero_a, zero_b, eq, gt;
    logic [63:0] key_a, key_b, sign_bit, val_mask;
    if (dbl) begin
      nan_a = (&a[62:52]) && (|a[51:0]);
      nan_b = (&b[62:52]) && (|b[51:0]);
      zero_a = ~|a[62:0];
      zero_b = ~|b[62:0];
      sign_bit = 64'h8000_0000_0000_0000;
      val_mask = '1;
    end else begin
      nan_a = (&a[30:23]) && (|a[22:0]);
      nan_b = (&b[30:23]) && (|b[22:0]);
      zero_a = ~|a[30:0];
      zero_b = ~|b[30:0];
      sign_bit = 64'h8000_0000;
      val_mask = 64'hFFFF_FFFF;
    end
    key_a = a & val_mask;
    key_b = b & val_mask;
    // map sign-magnitude onto an unsigned order
    key_a = (key_a & sign_bit) ? (~key_a & val_mask) : (key_a | sign_bit);
    key_b = (key_b & sign_bit) ? (~key_b & val_mask) : (key_b | sign_bit);
    if (nan_a || nan_b) begin
      eq = 1'b0;
      gt = 1'b0;
    end else if (zero_a && zero_b) begin
      eq = 1'b1;
      gt = 1'b0;
    end else begin
      eq = key_a == key_b;
      gt = key_a > key_b;
    end
    case (op)
      tcb_pkg::OP_EQ: return eq;
      tcb_pkg::OP_NE: return !eq;
      tcb_pkg::OP_GT: return gt;
      default:        return gt || eq;
    endcase
  endfunction

  function automatic logic compare_elem(logic [63:0] a, logic [63:0] b);
    logic [3:0]  t;
    int          w;
    logic [63:0] mask;
    if (cur_type == tcb_pkg::ELEM_F32) return compare_float(a, b, 1'b0, cur_op);
    if (cur_type == tcb_pkg::ELEM_F64) return compare_float(a, b, 1'b1, cur_op);
    t = (cur_type > tcb_pkg::ELEM_F64) ? tcb_pkg::ELEM_U64 : cur_type;
    w = 8 << (t >> 1);
    mask = (w == 64) ? '1 : ((64'd1 << w) - 64'd1);
    a &= mask;
    b &= mask;
    if (t[0]) begin
      a ^= 64'd1 << (w - 1);
      b ^= 64'd1 << (w - 1);
    end
    case (cur_op)
      tcb_pkg::OP_EQ: return a == b;
      tcb_pkg::OP_NE: return a != b;
      tcb_pkg::OP_GT: return a > b;
      default:        return a >= b;
    endcase
  endfunction

  // Place one result bit; queue a byte when it fills or the array ends
  task automatic pack_result(elem_pair_t p);
    logic [63:0]  a, b;
    logic         r;
    bitmap_byte_t e;
    a = p.left_val;
    b = p.right_val;
    if (cur_mode == tcb_pkg::MODE_R_SCALAR) b = cur_scalar;
    else if (cur_mode == tcb_pkg::MODE_L_SCALAR) a = cur_scalar;
    r = compare_elem(a, b);
    if (!in_array) begin
      acc_pos = cur_start;
      acc_bits = '0;
      acc_mask = '0;
    end
    acc_bits[acc_pos] = r;
    acc_mask[acc_pos] = 1'b1;
    if (acc_pos == 3'd7 || p.last_elem) begin
      e.bits = acc_bits;
      e.mask = acc_mask;
      e.last_byte = p.last_elem;
      expected_bytes.push_back(e);
      acc_bits = '0;
      acc_mask = '0;
      acc_pos = '0;
      in_array = !p.last_elem;
    end else begin
      acc_pos = acc_pos + 3'd1;
      in_array = 1'b1;
    end
  endtask

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("ERROR %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  // Driver: present pending pairs with random gaps
  int   send_gap = 0;
  logic send_busy = 1'b0;
  logic send_burst = 1'b0;

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      pack_result(pending_pairs.pop_front());
      send_busy <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && !send_busy) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        s_axis_tdata <= {pending_pairs[0].right_val, pending_pairs[0].left_val};
        s_axis_tlast <= pending_pairs[0].last_elem;
        s_axis_tvalid <= 1'b1;
        send_busy <= 1'b1;
        if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
        send_gap = send_burst ? 0 : $urandom_range(0, 5);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls between transactions
  int   recv_stall = 0;
  logic recv_burst = 1'b0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: check each output transaction against the oldest expected byte
  always @(posedge clk_i) begin
    bitmap_byte_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
      recv_stall = recv_burst ? 0 : $urandom_range(0, 5);
      if (expected_bytes.size() == 0) begin
        report("unexpected byte", m_axis_tdata, 16'h0);
      end else begin
        e = expected_bytes.pop_front();
        if (m_axis_tdata[7:0] !== e.bits)
          report("bitmap_byte", {8'd0, m_axis_tdata[7:0]}, {8'd0, e.bits});
        if (m_axis_tdata[15:8] !== e.mask)
          report("bit_mask", {8'd0, m_axis_tdata[15:8]}, {8'd0, e.mask});
        if (m_axis_tlast !== e.last_byte)
          report("last_byte", {15'd0, m_axis_tlast}, {15'd0, e.last_byte});
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      tcb_pkg::REG_ELEM_TYPE:    cur_type = val[3:0];
      tcb_pkg::REG_CMP_OP:       cur_op = val[1:0];
      tcb_pkg::REG_OPERAND_MODE: cur_mode = val[1:0];
      tcb_pkg::REG_SCALAR_VALUE: cur_scalar = val;
      tcb_pkg::REG_START_BIT:    cur_start = val[2:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [3:0] t, logic [1:0] op, logic [1:0] mode,
                            logic [63:0] sc, logic [2:0] sb);
    write_reg(tcb_pkg::REG_ELEM_TYPE, {60'd0, t});
    write_reg(tcb_pkg::REG_CMP_OP, {62'd0, op});
    write_reg(tcb_pkg::REG_OPERAND_MODE, {62'd0, mode});
    write_reg(tcb_pkg::REG_SCALAR_VALUE, sc);
    write_reg(tcb_pkg::REG_START_BIT, {61'd0, sb});
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every queued pair is taken and every byte has come back
  task automatic drain();
    while (pending_pairs.size() > 0 || send_busy || expected_bytes.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_pair(logic [63:0] a, logic [63:0] b, logic last);
    elem_pair_t p;
    p.left_val = a;
    p.right_val = b;
    p.last_elem = last;
    pending_pairs.push_back(p);
  endtask

  // Operand values biased toward boundaries and float specials
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0: v = '0;
      1: v = '1;
      2: v = 64'h8000_0000_0000_0000;
      3: v = 64'h7FF8_0000_0000_0001;
      4: v = 64'h7FF0_0000_0000_0000;
      5: v = 64'h0000_0000_7FC0_0001;
      6: v = 64'h0000_0000_8000_0000;
      7: v = 64'h0000_0000_7F80_0000;
      8: v = 64'($urandom_range(0, 3));
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    int n, pair_total, len;
    logic [63:0] a, b;
    cur_type = tcb_pkg::ELEM_U8;
    cur_op = tcb_pkg::OP_EQ;
    cur_mode = tcb_pkg::MODE_BOTH;
    cur_scalar = '0;
    cur_start = '0;
    acc_bits = '0;
    acc_mask = '0;
    acc_pos = '0;
    in_array = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: extremes of the raw words, a one-element array
    push_pair('0, '0, 1'b1);
    push_pair('1, '1, 1'b0);
    push_pair('1, '0, 1'b0);
    push_pair(64'h00FF, 64'h0100, 1'b1);
    drain();

    // Signed widths at the sign boundary, S8 starting in the top bit
    set_config(tcb_pkg::ELEM_S8, tcb_pkg::OP_GT, tcb_pkg::MODE_BOTH, '0, 3'd7);
    push_pair(64'h7F, 64'h80, 1'b0);
    push_pair(64'h80, 64'h7F, 1'b1);
    drain();
    set_config(tcb_pkg::ELEM_S64, tcb_pkg::OP_GE, tcb_pkg::MODE_R_SCALAR,
               64'h8000_0000_0000_0000, 3'd3);
    push_pair(64'h8000_0000_0000_0000, '1, 1'b0);
    push_pair(64'h7FFF_FFFF_FFFF_FFFF, '0, 1'b1);
    drain();

    // Float NaN and signed zeros
    set_config(tcb_pkg::ELEM_F32, tcb_pkg::OP_EQ, tcb_pkg::MODE_BOTH, '0, 3'd0);
    push_pair(64'h0000_0000, 64'h8000_0000, 1'b0);
    push_pair(64'h7FC0_0000, 64'h7FC0_0000, 1'b0);
    push_pair(64'h3F80_0000, 64'h3F80_0000, 1'b1);
    drain();
    set_config(tcb_pkg::ELEM_F64, tcb_pkg::OP_NE, tcb_pkg::MODE_L_SCALAR,
               64'h7FF8_0000_0000_0000, 3'd5);
    push_pair('0, 64'h7FF8_0000_0000_0000, 1'b0);
    push_pair('0, '0, 1'b1);
    drain();
    // Unused type and operand mode codes
    set_config(4'd15, tcb_pkg::OP_GT, 2'd3, '1, 3'd2);
    push_pair('1, 64'h1, 1'b1);
    drain();

    // Random phases with random configurations
    pair_total = 0;
    n = 0;
    while (pair_total < 1500) begin
      set_config(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                 2'($urandom_range(0, 3)), pick_value(), 3'($urandom_range(0, 7)));
      repeat ($urandom_range(1, 4)) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 24);
        for (int i = 0; i < len; i++) begin
          a = pick_value();
          b = ($urandom_range(0, 3) == 0) ? a : pick_value();
          push_pair(a, b, i == len - 1);
          pair_total++;
          // sender holds mid-array until all bytes are back
          if (n == 3 && i == len / 2) begin
            while (pending_pairs.size() > 0 || send_busy || expected_bytes.size() > 0)
              @(posedge clk_i);
          end
        end
      end
      n++;
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("typed_compare_to_bitmap_top: match");
    end else begin
      $display("typed_compare_to_bitmap_top: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("typed_compare_to_bitmap_top: mismatch");
    $finish;
  end

endmodule

[filelist.f]
rtl/tcb_pkg.sv
rtl/tcb_compare.sv
rtl/typed_compare_to_bitmap_top.sv
tb/typed_compare_to_bitmap_top_test.sv
